[sv/fat_block_allocator_assert.svh]
`ifndef FAT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FAT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fba_pkg.sv]
package fba_pkg;

	// fixed field widths
	localparam int SIZE_W  = 10;
	localparam int SUM_W   = 13;
	localparam int RECIP_W = 14;
	localparam int NEED_W  = 7;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LIST   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NO_SLOT  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        file_slot;
		logic [SIZE_W-1:0] file_size;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [2:0]        slot;
		logic [3:0]        block_index;
		logic              block_valid;
		logic [SIZE_W-1:0] size_bytes;
		logic              last;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t             kind;
		logic [2:0]        file_slot;
		logic [SIZE_W-1:0] size;
		logic              too_big;
		logic              slot_oob;
		logic [NEED_W-1:0] need;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_ALLOC,
		BK_FREE,
		BK_LIST
	} back_state_t;

endpackage

[sv/fba_fifo.sv]
module fba_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[sv/fba_ram.sv]
module fba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/fba_front.sv]
module fba_front #(
	parameter int NUM_BLOCKS  = 16,
	parameter int NUM_SLOTS   = 8,
	parameter int BLOCK_BYTES = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  fba_pkg::in_item_t request,
	input  logic             cmd_full,
	output logic             cmd_push,
	output fba_pkg::cmd_t    cmd
);

	localparam int SW        = $clog2(NUM_SLOTS);
	localparam int DIV_SHIFT = fba_pkg::SUM_W + $clog2(BLOCK_BYTES);
	localparam int RECIP     = ((1 << DIV_SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int PROD_W    = fba_pkg::SUM_W + fba_pkg::RECIP_W;

	logic                          valid_s1;
	fba_pkg::in_item_t             req_s1;
	logic                          valid_s2;
	fba_pkg::in_item_t             req_s2;
	logic [PROD_W-1:0]             prod_s2;

	logic [fba_pkg::SUM_W-1:0]     round_sum;
	logic [fba_pkg::RECIP_W-1:0]   recip;
	logic [PROD_W-1:0]             prod;
	logic [PROD_W-1:0]             quot;
	logic [SW+2:0]                 slot_ext;
	logic                          keep;
	logic                          s1_leave;
	logic                          s1_open;
	logic                          s2_leave;
	logic                          s2_open;
	logic                          accept;

	// handshake between the two stages and the command queue
	assign keep     = (req_s2.kind == fba_pkg::KIND_CREATE)
	               || (req_s2.kind == fba_pkg::KIND_REMOVE)
	               || (req_s2.kind == fba_pkg::KIND_LIST);
	assign s2_leave = valid_s2 && (!keep || !cmd_full);
	assign s2_open  = !valid_s2 || s2_leave;
	assign s1_leave = valid_s1 && s2_open;
	assign s1_open  = !valid_s1 || s1_leave;
	assign full     = !s1_open;
	assign accept   = push && s1_open;
	assign cmd_push = valid_s2 && keep && !cmd_full;

	// ceil(size / block bytes) as a reciprocal multiply, exact over the size range
	assign round_sum = fba_pkg::SUM_W'(req_s1.file_size) + fba_pkg::SUM_W'(BLOCK_BYTES - 1);
	assign recip     = fba_pkg::RECIP_W'(RECIP);
	assign prod      = PROD_W'(round_sum) * PROD_W'(recip);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_leave) begin
				valid_s1 <= 1'b0;
			end
			if (s1_leave) begin
				valid_s2 <= 1'b1;
			end else if (s2_leave) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
		if (s1_leave) begin
			req_s2  <= req_s1;
			prod_s2 <= prod;
		end
	end

	// classify the request for the back end
	always_comb begin
		quot     = prod_s2 >> DIV_SHIFT;
		slot_ext = {SW'(0), req_s2.file_slot};
		cmd.kind      = fba_pkg::kind_t'(req_s2.kind);
		cmd.file_slot = req_s2.file_slot;
		cmd.size      = req_s2.file_size;
		cmd.too_big   = (quot > PROD_W'(NUM_BLOCKS));
		cmd.slot_oob  = (slot_ext >= (SW + 3)'(NUM_SLOTS));
		cmd.need      = cmd.too_big ? '0 : quot[fba_pkg::NEED_W-1:0];
	end

endmodule

[sv/fba_back.sv]
`include "fat_block_allocator_assert.svh"

module fba_back #(
	parameter int NUM_BLOCKS = 16,
	parameter int NUM_SLOTS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  fba_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output fba_pkg::out_item_t res
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = IW + 1;
	localparam int SW = $clog2(NUM_SLOTS);

	fba_pkg::back_state_t state_q;
	fba_pkg::back_state_t state_d;
	fba_pkg::cmd_t        cmd_q;
	logic [SW-1:0]        slot_q;
	logic [SW-1:0]        slot_d;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        idx_d;
	logic [IW-1:0]        blk_q;
	logic [IW-1:0]        blk_d;
	logic [CW-1:0]        free_q;
	logic [NUM_BLOCKS-1:0] block_used_q;
	logic [NUM_SLOTS-1:0] slot_used_q;
	logic [fba_pkg::SIZE_W-1:0] slot_size_q [NUM_SLOTS];
	logic [CW-1:0]        slot_cnt_q [NUM_SLOTS];

	logic [SW+2:0]        in_slot_ext;
	logic [SW-1:0]        in_slot;
	logic [SW-1:0]        free_slot;
	logic                 slot_found;
	logic [SW+2:0]        free_ext;
	logic [SW+2:0]        cur_ext;
	logic [IW+3:0]        blk_ext;
	logic [IW+3:0]        rd_ext;
	logic [IW-1:0]        rd_blk;
	logic [CW-1:0]        cur_cnt;
	logic [fba_pkg::SIZE_W-1:0] cur_size;
	logic                 need_over;
	logic                 alloc_last;
	logic                 list_last;
	logic                 rd_ok;
	logic                 mark;
	logic                 unmark;
	logic                 set_slot;
	logic                 clr_slot;
	logic                 ram_we;

	// block list store, one row of NUM_BLOCKS entries per slot
	fba_ram #(
		.WIDTH (IW),
		.DEPTH (NUM_SLOTS << IW)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({slot_q, idx_q[IW-1:0]}),
		.wdata (blk_q),
		.raddr ({slot_d, idx_d[IW-1:0]}),
		.rdata (rd_blk)
	);

	// lowest free slot
	always_comb begin
		free_slot  = '0;
		slot_found = 1'b0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (!slot_used_q[s]) begin
				free_slot  = SW'(s);
				slot_found = 1'b1;
			end
		end
	end

	// field views and per-slot lookups
	assign in_slot_ext = {SW'(0), cmd.file_slot};
	assign in_slot     = in_slot_ext[SW-1:0];
	assign free_ext    = {3'b000, free_slot};
	assign cur_ext     = {3'b000, slot_q};
	assign blk_ext     = {4'b0000, blk_q};
	assign rd_ext      = {4'b0000, rd_blk};
	assign cur_cnt     = slot_cnt_q[slot_q];
	assign cur_size    = slot_size_q[slot_q];
	assign need_over   = cmd_q.need > fba_pkg::NEED_W'(free_q);
	assign alloc_last  = (idx_q + CW'(1)) == CW'(cmd_q.need);
	assign list_last   = (idx_q + CW'(1)) == cur_cnt;
	assign rd_ok       = (CW'(rd_blk) < CW'(NUM_BLOCKS)) && block_used_q[rd_blk];

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		idx_d    = idx_q;
		blk_d    = blk_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		mark     = 1'b0;
		unmark   = 1'b0;
		set_slot = 1'b0;
		clr_slot = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			fba_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					slot_d  = in_slot;
					idx_d   = '0;
					blk_d   = '0;
					state_d = fba_pkg::BK_CHECK;
				end
			end
			fba_pkg::BK_CHECK: begin
				case (cmd_q.kind)
					fba_pkg::KIND_CREATE: begin
						res.last = 1'b1;
						if (cmd_q.too_big || need_over) begin
							res.status = fba_pkg::ST_NO_SPACE;
							if (!res_full) begin
								res_push = 1'b1;
								state_d  = fba_pkg::BK_IDLE;
							end
						end else if (!slot_found) begin
							res.status = fba_pkg::ST_NO_SLOT;
							if (!res_full) begin
								res_push = 1'b1;
								state_d  = fba_pkg::BK_IDLE;
							end
						end else if (cmd_q.need == '0) begin
							res.status     = fba_pkg::ST_OK;
							res.slot       = free_ext[2:0];
							res.size_bytes = cmd_q.size;
							if (!res_full) begin
								res_push = 1'b1;
								set_slot = 1'b1;
								slot_d   = free_slot;
								state_d  = fba_pkg::BK_IDLE;
							end
						end else begin
							set_slot = 1'b1;
							slot_d   = free_slot;
							state_d  = fba_pkg::BK_ALLOC;
						end
					end
					fba_pkg::KIND_REMOVE, fba_pkg::KIND_LIST: begin
						res.last = 1'b1;
						if (cmd_q.slot_oob || !slot_used_q[slot_q]) begin
							res.status = fba_pkg::ST_EMPTY;
							res.slot   = cmd_q.file_slot;
							if (!res_full) begin
								res_push = 1'b1;
								state_d  = fba_pkg::BK_IDLE;
							end
						end else if (cmd_q.kind == fba_pkg::KIND_REMOVE) begin
							state_d = fba_pkg::BK_FREE;
						end else if (cur_cnt == '0) begin
							res.status     = fba_pkg::ST_OK;
							res.slot       = cur_ext[2:0];
							res.size_bytes = cur_size;
							if (!res_full) begin
								res_push = 1'b1;
								state_d  = fba_pkg::BK_IDLE;
							end
						end else begin
							state_d = fba_pkg::BK_LIST;
						end
					end
					default: begin
						state_d = fba_pkg::BK_IDLE;
					end
				endcase
			end
			fba_pkg::BK_ALLOC: begin
				// first-fit scan, one block a cycle, holding on a free block while the result queue is full
				if (!block_used_q[blk_q]) begin
					res.status      = fba_pkg::ST_OK;
					res.slot        = cur_ext[2:0];
					res.block_index = blk_ext[3:0];
					res.block_valid = 1'b1;
					res.size_bytes  = cmd_q.size;
					res.last        = alloc_last;
					if (!res_full) begin
						res_push = 1'b1;
						mark     = 1'b1;
						ram_we   = 1'b1;
						idx_d    = idx_q + CW'(1);
						blk_d    = blk_q + IW'(1);
						if (alloc_last) begin
							state_d = fba_pkg::BK_IDLE;
						end
					end
				end else begin
					blk_d = blk_q + IW'(1);
				end
			end
			fba_pkg::BK_FREE: begin
				// walk the block list; the read is addressed with idx_d, so its data matches idx_q
				if (idx_q < cur_cnt) begin
					unmark = rd_ok;
					idx_d  = idx_q + CW'(1);
				end else begin
					res.status     = fba_pkg::ST_OK;
					res.slot       = cur_ext[2:0];
					res.size_bytes = cur_size;
					res.last       = 1'b1;
					if (!res_full) begin
						res_push = 1'b1;
						clr_slot = 1'b1;
						state_d  = fba_pkg::BK_IDLE;
					end
				end
			end
			fba_pkg::BK_LIST: begin
				// hold the index while stalled so the read repeats
				res.status      = fba_pkg::ST_OK;
				res.slot        = cur_ext[2:0];
				res.block_index = rd_ext[3:0];
				res.block_valid = 1'b1;
				res.size_bytes  = cur_size;
				res.last        = list_last;
				if (!res_full) begin
					res_push = 1'b1;
					if (list_last) begin
						state_d = fba_pkg::BK_IDLE;
					end else begin
						idx_d = idx_q + CW'(1);
					end
				end
			end
			default: begin
				state_d = fba_pkg::BK_IDLE;
			end
		endcase
	end

	// control state, block map and slot map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fba_pkg::BK_IDLE;
			slot_q       <= '0;
			idx_q        <= '0;
			blk_q        <= '0;
			free_q       <= CW'(NUM_BLOCKS);
			block_used_q <= '0;
			slot_used_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			idx_q   <= idx_d;
			blk_q   <= blk_d;
			if (mark) begin
				block_used_q[blk_q] <= 1'b1;
				free_q              <= free_q - CW'(1);
			end else if (unmark) begin
				block_used_q[rd_blk] <= 1'b0;
				free_q               <= free_q + CW'(1);
			end
			if (set_slot) begin
				slot_used_q[free_slot] <= 1'b1;
			end else if (clr_slot) begin
				slot_used_q[slot_q] <= 1'b0;
			end
		end
	end

	// request and per-slot records
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (set_slot) begin
			slot_size_q[free_slot] <= cmd_q.size;
			slot_cnt_q[free_slot]  <= CW'(cmd_q.need);
		end
	end

	`FBA_ASSERT_NOW(a_free_bounded, 1'b1, free_q <= CW'(NUM_BLOCKS), "free count above pool size")
	`FBA_ASSERT_NOW(a_free_matches_map, 1'b1, (32'($countones(block_used_q)) + 32'(free_q)) == 32'(NUM_BLOCKS), "free count disagrees with block map")
	`FBA_ASSERT_NOW(a_scan_in_pool, state_q == fba_pkg::BK_ALLOC, 32'(blk_q) < 32'(NUM_BLOCKS), "allocation scan ran off the pool")
	`FBA_ASSERT_NEXT(a_last_ends_request, res_push && res.last, state_q == fba_pkg::BK_IDLE, "final transfer did not end the request")

endmodule

[sv/fat_block_allocator.sv]
// File allocation table over NUM_BLOCKS blocks of BLOCK_BYTES bytes with NUM_SLOTS file slots.
// Requests enter through a two-stage front end (block count by reciprocal multiply, request
// classification) and wait in a two-entry command queue; the back end serves one request at a
// time and writes results into a two-entry result queue. In the back end a create checks space
// and then the slot, then scans the free map first-fit; a remove walks the block list of the
// file before its one result; a list reads out one transfer per block; an error or zero-block
// result is a single transfer. Results of one request come out in file order with last set on
// the final transfer; kind 3 is dropped in the front end and gives no transfer. The block list
// store is not cleared after reset: it is only read for slots that create has written.
module fat_block_allocator #(
	parameter int NUM_BLOCKS  = 16,
	parameter int NUM_SLOTS   = 8,
	parameter int BLOCK_BYTES = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  fba_pkg::in_item_t  request,
	output logic               empty,
	input  logic               pop,
	output fba_pkg::out_item_t response
);

	logic               cmd_push;
	logic               cmd_full;
	logic               cmd_pop;
	logic               cmd_empty;
	fba_pkg::cmd_t      cmd_in;
	fba_pkg::cmd_t      cmd_out;
	logic               res_push;
	logic               res_full;
	fba_pkg::out_item_t res;

	// request intake and classification
	fba_front #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.NUM_SLOTS   (NUM_SLOTS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// command queue between front and back
	fba_fifo #(
		.WIDTH ($bits(fba_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// table walk and update
	fba_back #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue towards the consumer
	fba_fifo #(
		.WIDTH ($bits(fba_pkg::out_item_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (response),
		.empty  (empty)
	);

endmodule

[verif/tb_fat_block_allocator.sv]
module tb_fat_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS  = 16;
	localparam int NUM_SLOTS   = 8;
	localparam int BLOCK_BYTES = 50;
	localparam int RANDOM_REQUESTS = 290;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	fba_pkg::in_item_t  request = '0;
	logic               empty;
	logic               pop = 1'b0;
	fba_pkg::out_item_t response;

	// stimulus and expectations
	fba_pkg::in_item_t  queued_requests[$];
	fba_pkg::out_item_t predicted_responses[$];
	int        total_requests;
	int        accepted_requests = 0;
	int        checked_responses = 0;
	int        failures = 0;
	int        status_seen[4];
	logic      hold_responses = 1'b0;

	// shadow of the allocation table
	bit         block_taken[NUM_BLOCKS];
	logic [4:0] free_blocks;
	bit         slot_taken[NUM_SLOTS];
	logic [9:0] slot_bytes[NUM_SLOTS];
	logic [4:0] slot_nblocks[NUM_SLOTS];
	logic [3:0] slot_chain[NUM_SLOTS][NUM_BLOCKS];

	fat_block_allocator #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.NUM_SLOTS  (NUM_SLOTS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.response(response)
	);

	always #2 clk = ~clk;

	// append one expected response and tally its status
	function automatic void owe_response(fba_pkg::status_t st, int slot, int blk, bit bvalid,
			int bytes, bit fin);
		fba_pkg::out_item_t r;
		r = '0;
		r.status      = st;
		r.slot        = slot[2:0];
		r.block_index = blk[3:0];
		r.block_valid = bvalid;
		r.size_bytes  = bytes[9:0];
		r.last        = fin;
		predicted_responses.push_back(r);
		status_seen[st]++;
	endfunction

	// first-fit allocation table behaviour for one accepted request
	function automatic void predict_fat_request(fba_pkg::in_item_t req);
		int need;
		int s;
		int i;
		int fs;
		need = 0;
		s = 0;
		i = 0;
		fs = req.file_slot;
		case (req.kind)
			fba_pkg::KIND_CREATE: begin
				need = req.file_size / BLOCK_BYTES + ((req.file_size % BLOCK_BYTES) != 0);
				// space is checked before the slot search
				if (need > free_blocks || need > NUM_BLOCKS) begin
					owe_response(fba_pkg::ST_NO_SPACE, 0, 0, 1'b0, 0, 1'b1);
					return;
				end
				while (s < NUM_SLOTS && slot_taken[s])
					s++;
				if (s >= NUM_SLOTS) begin
					owe_response(fba_pkg::ST_NO_SLOT, 0, 0, 1'b0, 0, 1'b1);
					return;
				end
				slot_taken[s]   = 1'b1;
				slot_bytes[s]   = req.file_size;
				slot_nblocks[s] = need[4:0];
				if (need == 0) begin
					owe_response(fba_pkg::ST_OK, s, 0, 1'b0, req.file_size, 1'b1);
					return;
				end
				for (int b = 0; b < NUM_BLOCKS && i < need; b++) begin
					if (!block_taken[b]) begin
						block_taken[b]  = 1'b1;
						slot_chain[s][i] = b[3:0];
						owe_response(fba_pkg::ST_OK, s, b, 1'b1, req.file_size,
							i + 1 == need);
						i++;
					end
				end
				free_blocks = free_blocks - need[4:0];
			end
			fba_pkg::KIND_REMOVE, fba_pkg::KIND_LIST: begin
				if (!slot_taken[fs]) begin
					owe_response(fba_pkg::ST_EMPTY, fs, 0, 1'b0, 0, 1'b1);
					return;
				end
				need = slot_nblocks[fs];
				if (req.kind == fba_pkg::KIND_REMOVE) begin
					for (i = 0; i < need; i++) begin
						if (block_taken[slot_chain[fs][i]]) begin
							block_taken[slot_chain[fs][i]] = 1'b0;
							free_blocks = free_blocks + 5'd1;
						end
					end
					slot_taken[fs] = 1'b0;
					owe_response(fba_pkg::ST_OK, fs, 0, 1'b0, slot_bytes[fs], 1'b1);
				end else if (need == 0) begin
					owe_response(fba_pkg::ST_OK, fs, 0, 1'b0, slot_bytes[fs], 1'b1);
				end else begin
					for (i = 0; i < need; i++)
						owe_response(fba_pkg::ST_OK, fs, slot_chain[fs][i], 1'b1,
							slot_bytes[fs], i + 1 == need);
				end
			end
			default: begin
				// unused kind is dropped without a transfer
			end
		endcase
	endfunction

	function automatic void report_field(string name, int want, int got);
		failures++;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endfunction

	// compare one response transfer against the oldest expectation
	function automatic void check_response(fba_pkg::out_item_t got);
		fba_pkg::out_item_t want;
		if (predicted_responses.size() == 0) begin
			failures++;
			$display("%0t ns: unexpected response, expected none, actual %p", $time, got);
			return;
		end
		want = predicted_responses.pop_front();
		checked_responses++;
		if (got.status !== want.status)
			report_field("status", want.status, got.status);
		if (got.slot !== want.slot)
			report_field("slot", want.slot, got.slot);
		if (got.block_index !== want.block_index)
			report_field("block_index", want.block_index, got.block_index);
		if (got.block_valid !== want.block_valid)
			report_field("block_valid", want.block_valid, got.block_valid);
		if (got.size_bytes !== want.size_bytes)
			report_field("size_bytes", want.size_bytes, got.size_bytes);
		if (got.last !== want.last)
			report_field("last", want.last, got.last);
	endfunction

	// idle phase: sender mostly busy, then receiver mostly busy, then no gaps
	function automatic int idle_phase();
		if (accepted_requests < total_requests / 3)
			return 0;
		if (accepted_requests < 2 * total_requests / 3)
			return 1;
		return 2;
	endfunction

	function automatic void queue_request(logic [1:0] kind, int slot, int bytes);
		fba_pkg::in_item_t r;
		r.kind      = kind;
		r.file_slot = slot[2:0];
		r.file_size = bytes[9:0];
		queued_requests.push_back(r);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_fat_request(request);
				accepted_requests++;
			end
			if (!(push && full)) begin
				if (queued_requests.size() != 0 &&
						$urandom_range(99) >= (idle_phase() == 0 ? 24 :
						idle_phase() == 1 ? 67 : 0)) begin
					request <= queued_requests.pop_front();
					push    <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_response(response);
			pop <= !hold_responses && $urandom_range(99) >= (idle_phase() == 0 ? 67 :
				idle_phase() == 1 ? 24 : 0);
		end
	end

	// long receiver stall so that the request side fills and backs up
	initial begin
		wait (accepted_requests >= 150);
		@(posedge clk);
		hold_responses <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_responses <= 1'b0;
	end

	// run limit
	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		int pick;
		int bytes;
		int counted;
		counted = 0;
		for (int b = 0; b < NUM_BLOCKS; b++)
			block_taken[b] = 1'b0;
		for (int s = 0; s < NUM_SLOTS; s++)
			slot_taken[s] = 1'b0;
		free_blocks = 5'(NUM_BLOCKS);

		// directed: zero-byte file, full pool, no space, no slot, empty slot
		queue_request(fba_pkg::KIND_CREATE, 7, 0);
		queue_request(fba_pkg::KIND_LIST, 0, 1023);
		queue_request(fba_pkg::KIND_CREATE, 0, 1023);
		queue_request(fba_pkg::KIND_CREATE, 5, 800);
		queue_request(fba_pkg::KIND_CREATE, 2, 1);
		queue_request(fba_pkg::KIND_LIST, 1, 0);
		queue_request(fba_pkg::KIND_REMOVE, 1, 1023);
		queue_request(fba_pkg::KIND_LIST, 1, 512);
		queue_request(fba_pkg::KIND_REMOVE, 1, 0);
		queue_request(fba_pkg::KIND_CREATE, 0, 50);
		queue_request(fba_pkg::KIND_CREATE, 0, 51);
		for (int k = 0; k < 5; k++)
			queue_request(fba_pkg::KIND_CREATE, 3, 0);
		queue_request(fba_pkg::KIND_CREATE, 0, 0);
		queue_request(fba_pkg::KIND_CREATE, 0, 1023);
		queue_request(KIND_UNUSED, 7, 1023);
		queue_request(fba_pkg::KIND_LIST, 2, 341);
		queue_request(fba_pkg::KIND_REMOVE, 7, 682);
		queue_request(fba_pkg::KIND_REMOVE, 0, 0);
		queue_request(fba_pkg::KIND_REMOVE, 2, 1023);
		queue_request(fba_pkg::KIND_LIST, 7, 1023);
		queue_request(fba_pkg::KIND_REMOVE, 1, 0);

		// random mix, mostly small files so the table keeps turning over
		while (counted < RANDOM_REQUESTS) begin
			pick = $urandom_range(99);
			if (pick < 55)
				bytes = $urandom_range(200);
			else if (pick < 85)
				bytes = $urandom_range(800);
			else
				bytes = $urandom_range(1023);
			pick = $urandom_range(99);
			if (pick < 42)
				queue_request(fba_pkg::KIND_CREATE, $urandom_range(7), bytes);
			else if (pick < 70)
				queue_request(fba_pkg::KIND_REMOVE, $urandom_range(7), bytes);
			else if (pick < 95)
				queue_request(fba_pkg::KIND_LIST, $urandom_range(7), bytes);
			else
				queue_request(KIND_UNUSED, $urandom_range(7), bytes);
			if (pick < 95)
				counted++;
		end
		total_requests = queued_requests.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		while (queued_requests.size() != 0 || push || predicted_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		failures += predicted_responses.size();

		$display("covered %0d requests and %0d response transfers", accepted_requests,
			checked_responses);
		$display("status mix: ok %0d, no space %0d, no slot %0d, slot empty %0d",
			status_seen[fba_pkg::ST_OK], status_seen[fba_pkg::ST_NO_SPACE],
			status_seen[fba_pkg::ST_NO_SLOT], status_seen[fba_pkg::ST_EMPTY]);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
